/* design/rfd_pkg.sv */
package rfd_pkg;

   // defaults for the top-level parameters
   localparam int MAX_FEATURES_DEF = 16;
   localparam int VALUE_BITS_DEF   = 16;

   // fixed field widths
   localparam int CSR_BITS  = 5;
   localparam int DIST_BITS = 16;

   // kind bit of an input word
   localparam logic KIND_REF = 1'b0;
   localparam logic KIND_ROW = 1'b1;

   // control sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_ACCUM,
      S_DIV,
      S_ROOT,
      S_OUT
   } state_type;

endpackage

/* design/rms_feature_distance_core.sv */
// RMS distance of row vectors from a stored reference vector.
// req_ channel: one feature word per handshake; req_kind selects a reference
// element (written to the reference RAM in order) or a row element (squared
// difference against the reference entry at the same position, accumulated).
// rsp_ channel: after num_features row elements one word carries
// floor(sqrt(sum / num_features)); the accumulator is then cleared.
// csr_ channel: num_features; the user writes it only while the block is idle,
// and the block itself does not enforce it. A reference word is taken in the
// idle state and leaves the block idle; a row word passes the steps accept and
// RAM read, square and accumulate, set by the single RAM read port and the
// registered multiplier, before the next word is taken. The last word of a row
// then passes the bit-serial divider, the bit-serial root and the output state.
// Reset clears positions, accumulator and output valid, and sets
// num_features to 1; the reference RAM holds junk until written.
// A result sits in the output register while rsp_ready is low; the block keeps
// taking words meanwhile and only waits if the next result is ready first.
module rms_feature_distance_core import rfd_pkg::*; #(
   parameter int MAX_FEATURES = MAX_FEATURES_DEF,
   parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic signed [VALUE_BITS-1:0] req_feature_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DIST_BITS-1:0]         rsp_distance,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_BITS-1:0]          csr_num_features
);

   localparam int POS_BITS  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_FEATURES + 1);
   localparam int SQ_BITS   = 2 * VALUE_BITS;
   localparam int SUM_BITS  = SQ_BITS + $clog2(MAX_FEATURES);
   localparam int ROOT_BITS = (SUM_BITS + 1) / 2;

   state_type               state_ff, state_in;
   logic [CSR_BITS-1:0]     nf_ff;
   logic [POS_BITS-1:0]     ref_pos_ff, ref_pos_in;
   logic [POS_BITS-1:0]     row_pos_ff, row_pos_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [VALUE_BITS-1:0]   val_ff;
   logic [SQ_BITS-1:0]      sq_ff, sq_in;
   logic                    rsp_valid_ff;
   logic [DIST_BITS-1:0]    rsp_distance_ff;

   logic [CNT_BITS-1:0]     count_active;
   logic [POS_BITS:0]       ref_inc, row_inc;
   logic                    ref_wrap, row_done;
   logic                    req_take, ref_write, row_read;
   logic [VALUE_BITS-1:0]   rd_data;
   logic signed [VALUE_BITS:0] diff;
   logic [VALUE_BITS:0]     mag;
   logic [SUM_BITS-1:0]     sum_new;
   logic                    div_start, div_done;
   logic [SUM_BITS-1:0]     quotient;
   logic                    root_start, root_done;
   logic [ROOT_BITS-1:0]    root;
   logic                    out_load;

   // effective feature count: zero reads as one, saturate at the RAM depth
   always_comb begin
      if (nf_ff == '0) begin
         count_active = CNT_BITS'(1);
      end else if (32'(nf_ff) > MAX_FEATURES) begin
         count_active = CNT_BITS'(MAX_FEATURES);
      end else begin
         count_active = CNT_BITS'(nf_ff);
      end
   end

   // input handshake decode
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign ref_write = req_take && (req_kind == KIND_REF);
   assign row_read  = req_take && (req_kind == KIND_ROW);

   // position counters with wrap at the active count
   assign ref_inc  = (POS_BITS + 1)'(ref_pos_ff) + 1'b1;
   assign row_inc  = (POS_BITS + 1)'(row_pos_ff) + 1'b1;
   assign ref_wrap = (32'(ref_inc) >= 32'(count_active));
   assign row_done = (32'(row_inc) >= 32'(count_active));

   always_comb begin
      ref_pos_in = ref_pos_ff;
      if (ref_write) begin
         ref_pos_in = ref_wrap ? '0 : ref_inc[POS_BITS-1:0];
      end
   end

   rfd_ref_mem #(
      .DEPTH     (MAX_FEATURES),
      .WIDTH     (VALUE_BITS),
      .ADDR_BITS (POS_BITS)
   ) u_ref_mem (
      .clock   (clock),
      .wr_en   (ref_write),
      .wr_addr (ref_pos_ff),
      .wr_data (req_feature_value),
      .rd_en   (row_read),
      .rd_addr (row_pos_ff),
      .rd_data (rd_data)
   );

   // squared difference against the reference entry
   always_comb begin
      diff  = $signed({val_ff[VALUE_BITS-1], val_ff}) - $signed({rd_data[VALUE_BITS-1], rd_data});
      mag   = diff[VALUE_BITS] ? (VALUE_BITS + 1)'(0) - diff : diff;
      sq_in = mag[VALUE_BITS-1:0] * mag[VALUE_BITS-1:0];
   end

   assign sum_new = sum_ff + SUM_BITS'(sq_ff);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      sum_in     = sum_ff;
      row_pos_in = row_pos_ff;
      div_start  = 1'b0;
      root_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (row_read) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            if (row_done) begin
               div_start  = 1'b1;
               sum_in     = '0;
               row_pos_in = '0;
               state_in   = S_DIV;
            end else begin
               sum_in     = sum_new;
               row_pos_in = row_inc[POS_BITS-1:0];
               state_in   = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               root_start = 1'b1;
               state_in   = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   rfd_divider #(
      .SUM_BITS (SUM_BITS),
      .CNT_BITS (CNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (count_active),
      .done     (div_done),
      .quotient (quotient)
   );

   rfd_sqrt #(
      .OP_BITS   (SUM_BITS),
      .ROOT_BITS (ROOT_BITS)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (quotient),
      .done    (root_done),
      .root    (root)
   );

   // output register loads when empty or being drained
   assign out_load = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nf_ff        <= CSR_BITS'(1);
         ref_pos_ff   <= '0;
         row_pos_ff   <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ref_pos_ff <= ref_pos_in;
         row_pos_ff <= row_pos_in;
         sum_ff     <= sum_in;
         if (csr_valid && csr_ready) begin
            nf_ff <= csr_num_features;
         end
         if ((state_ff == S_OUT) && out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         val_ff <= req_feature_value;
      end
      if (state_ff == S_SQUARE) begin
         sq_ff <= sq_in;
      end
      if ((state_ff == S_OUT) && out_load) begin
         rsp_distance_ff <= DIST_BITS'(root);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   // a row word always starts the square step
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_ROW)) |=> (state_ff == S_SQUARE))
      else $error("row word did not start the square step");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside its wait state");

   // root unit finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_ROOT))
      else $error("root unit finished outside its wait state");

   // accumulator is clear while a result is on its way out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> ((sum_ff == '0) && (row_pos_ff == '0)))
      else $error("accumulator not cleared at row end");

endmodule

/* design/rfd_ref_mem.sv */
module rfd_ref_mem import rfd_pkg::*; #(
   parameter int DEPTH     = MAX_FEATURES_DEF,
   parameter int WIDTH     = VALUE_BITS_DEF,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // one read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rfd_divider.sv */
module rfd_divider import rfd_pkg::*; #(
   parameter int SUM_BITS = 2 * VALUE_BITS_DEF + $clog2(MAX_FEATURES_DEF),
   parameter int CNT_BITS = $clog2(MAX_FEATURES_DEF + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0] divisor,
   output logic                done,
   output logic [SUM_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(SUM_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]  dsr_ff, dsr_in;
   logic [CNT_BITS:0]    shifted;
   logic [CNT_BITS:0]    diff;
   logic                 take;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_BITS-1]};
      diff    = shifted - {1'b0, dsr_ff};
      take    = (shifted >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_BITS-2:0], take};
         rem_in  = take ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/rfd_sqrt.sv */
module rfd_sqrt import rfd_pkg::*; #(
   parameter int OP_BITS   = 2 * VALUE_BITS_DEF + $clog2(MAX_FEATURES_DEF),
   parameter int ROOT_BITS = (OP_BITS + 1) / 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [OP_BITS-1:0]   operand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);

   localparam int PAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int STEP_BITS = $clog2(ROOT_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [PAD_BITS-1:0]  op_ff, op_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [REM_BITS+1:0]  shifted;
   logic [REM_BITS+1:0]  trial;
   logic                 take;

   // digit-by-digit root, one result bit per cycle
   always_comb begin
      shifted = {rem_ff, op_ff[PAD_BITS-1 -: 2]};
      trial   = (REM_BITS + 2)'({root_ff, 2'b01});
      take    = (shifted >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         op_in   = PAD_BITS'(operand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         op_in   = op_ff << 2;
         rem_in  = take ? REM_BITS'(shifted - trial) : REM_BITS'(shifted);
         root_in = {root_ff[ROOT_BITS-2:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
